// File: rtl/core/cpbf_pkg.sv
// Shared types and constants for the brute-force closest-pair block.
// Used by cpbf_cell and closest_pair_brute_force; depends on nothing.
package cpbf_pkg;

   localparam int unsigned COORD_W        = 16;
   localparam int unsigned SQ_W           = 32;
   localparam int unsigned DIST_W         = 33;
   localparam int unsigned BEST_W         = 34;
   localparam int unsigned MAX_POINTS_DEF = 64;

   localparam logic [BEST_W-1:0] DIST_NONE = '1;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Running best pair as it travels down the cell row.
   typedef struct packed {
      logic              vld;
      logic [BEST_W-1:0] dist_sq;
      coord_type         ax;
      coord_type         ay;
      coord_type         bx;
      coord_type         by;
   } tok_type;

endpackage

// File: rtl/core/cpbf_cell.sv
// One storage cell of the closest-pair row: holds a point, computes its squared
// distance to the new point, and updates the best-pair token in passing. Uses cpbf_pkg.
module cpbf_cell #(
   parameter int unsigned MAX_POINTS = cpbf_pkg::MAX_POINTS_DEF,
   parameter int unsigned CELL_IDX   = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cpbf_pkg::coord_type               np_x,
   input  cpbf_pkg::coord_type               np_y,
   input  logic [$clog2(MAX_POINTS+1)-1:0]   count,
   input  logic                              wr_en,
   input  cpbf_pkg::tok_type                 tok_in,
   input  logic [$clog2(MAX_POINTS)-1:0]     tok_idx_in,
   output cpbf_pkg::tok_type                 tok_out,
   output logic [$clog2(MAX_POINTS)-1:0]     tok_idx_out
);
   import cpbf_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
   localparam int unsigned IDX_W = $clog2(MAX_POINTS);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   coord_type               pt_x_ff, pt_y_ff;
   logic [COORD_W-1:0]      adx_ff, ady_ff, adx_in, ady_in;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff;
   logic [DIST_W-1:0]       d_ff;
   logic signed [COORD_W:0] dx, dy, adx_full, ady_full;
   logic [BEST_W-1:0]       d_ext;
   logic                    cell_vld, better;
   tok_type                 tok_ff, tok_in_next;
   logic [IDX_W-1:0]        idx_ff, idx_in;

   // |dx| and |dy| fit in 16 unsigned bits
   always_comb begin
      dx       = {np_x[COORD_W-1], np_x} - {pt_x_ff[COORD_W-1], pt_x_ff};
      dy       = {np_y[COORD_W-1], np_y} - {pt_y_ff[COORD_W-1], pt_y_ff};
      adx_full = dx[COORD_W] ? -dx : dx;
      ady_full = dy[COORD_W] ? -dy : dy;
      adx_in   = adx_full[COORD_W-1:0];
      ady_in   = ady_full[COORD_W-1:0];
   end

   assign cell_vld = MY_CNT < count;
   assign d_ext    = {1'b0, d_ff};
   assign better   = cell_vld && tok_in.vld &&
                     ((d_ext < tok_in.dist_sq) ||
                      ((d_ext == tok_in.dist_sq) && (MY_IDX < tok_idx_in)));

   always_comb begin
      tok_in_next = tok_in;
      idx_in      = tok_idx_in;
      if (better) begin
         tok_in_next.dist_sq = d_ext;
         tok_in_next.ax      = pt_x_ff;
         tok_in_next.ay      = pt_y_ff;
         tok_in_next.bx      = np_x;
         tok_in_next.by      = np_y;
         idx_in              = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (count == MY_CNT)) begin
         pt_x_ff <= np_x;
         pt_y_ff <= np_y;
      end
      adx_ff <= adx_in;
      ady_ff <= ady_in;
      sqx_ff <= adx_ff * adx_ff;
      sqy_ff <= ady_ff * ady_ff;
      d_ff   <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      idx_ff <= idx_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out     = tok_ff;
   assign tok_idx_out = idx_ff;

endmodule

// File: rtl/core/closest_pair_brute_force.sv
// Top level of the brute-force closest-pair block: control, best-pair state and
// result register around a row of cpbf_cell instances. Uses cpbf_pkg.
//
// Points arrive one per transfer on the req_ channel; the transfer with
// req_last_point set closes the set and produces one rsp_ transfer carrying the
// exact squared distance of the closest pair, both points (earlier point first),
// pair_found and overflowed. Each accepted point that fits first passes the
// distance pipeline in every cell (absolute differences, squares, sum), then the
// best-pair token walks the cell row one cell per cycle, then the point is
// written into the next free cell. A point that arrives with the store full is
// dropped and sets the overflow flag. A finished result sits in an output
// register; a further closing point waits until that register is taken.
// The store needs no clearing pass after reset or between sets.
module closest_pair_brute_force #(
   parameter int unsigned MAX_POINTS = cpbf_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cpbf_pkg::coord_type           req_px,
   input  cpbf_pkg::coord_type           req_py,
   input  logic                          req_last_point,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cpbf_pkg::DIST_W-1:0]   rsp_min_sq_dist,
   output cpbf_pkg::coord_type           rsp_first_x,
   output cpbf_pkg::coord_type           rsp_first_y,
   output cpbf_pkg::coord_type           rsp_second_x,
   output cpbf_pkg::coord_type           rsp_second_y,
   output logic                          rsp_pair_found,
   output logic                          rsp_overflowed
);
   import cpbf_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
   localparam int unsigned IDX_W = $clog2(MAX_POINTS);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_POINTS);
   localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [1:0]        settle_ff;
   coord_type         np_x_ff, np_y_ff;
   logic              last_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [BEST_W-1:0] best_dist_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   coord_type         best_ax_ff, best_ay_ff, best_bx_ff, best_by_ff;
   logic              overflow_ff;

   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   coord_type         rsp_ax_ff, rsp_ay_ff, rsp_bx_ff, rsp_by_ff;
   logic              rsp_found_ff, rsp_ovf_ff;

   tok_type           tok_w [MAX_POINTS+1];
   logic [IDX_W-1:0]  idx_w [MAX_POINTS+1];

   logic              accept, inject, walk_done, wr_en, rsp_free, found;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign inject    = (state_ff == ST_SETTLE) && (settle_ff == 2'd3);
   assign walk_done = (state_ff == ST_WALK) && tok_w[MAX_POINTS].vld;
   assign wr_en     = walk_done;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign found     = count_ff >= TWO_CNT;

   // Launch the current best pair into the head of the row once distances settle.
   always_comb begin
      tok_w[0].vld     = inject;
      tok_w[0].dist_sq = best_dist_ff;
      tok_w[0].ax      = best_ax_ff;
      tok_w[0].ay      = best_ay_ff;
      tok_w[0].bx      = best_bx_ff;
      tok_w[0].by      = best_by_ff;
      idx_w[0]         = best_idx_ff;
   end

   for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
      cpbf_cell #(
         .MAX_POINTS (MAX_POINTS),
         .CELL_IDX   (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .np_x        (np_x_ff),
         .np_y        (np_y_ff),
         .count       (count_ff),
         .wr_en       (wr_en),
         .tok_in      (tok_w[g]),
         .tok_idx_in  (idx_w[g]),
         .tok_out     (tok_w[g+1]),
         .tok_idx_out (idx_w[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         settle_ff    <= '0;
         last_ff      <= 1'b0;
         count_ff     <= '0;
         best_dist_ff <= DIST_NONE;
         best_idx_ff  <= '0;
         best_ax_ff   <= '0;
         best_ay_ff   <= '0;
         best_bx_ff   <= '0;
         best_by_ff   <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once the consumer takes it, unless a new one
         // is loaded in the same cycle.
         if (rsp_valid_ff && rsp_ready && !((state_ff == ST_FINISH) && last_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  np_x_ff   <= req_px;
                  np_y_ff   <= req_py;
                  last_ff   <= req_last_point;
                  settle_ff <= '0;
                  if (count_ff == FULL_CNT) begin
                     overflow_ff <= 1'b1;
                     state_ff    <= ST_FINISH;
                  end else begin
                     state_ff <= ST_SETTLE;
                  end
               end
            end
            ST_SETTLE: begin
               settle_ff <= settle_ff + 2'd1;
               if (inject) begin
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               // Take the best pair from the tail of the row and store the point.
               if (walk_done) begin
                  best_dist_ff <= tok_w[MAX_POINTS].dist_sq;
                  best_idx_ff  <= idx_w[MAX_POINTS];
                  best_ax_ff   <= tok_w[MAX_POINTS].ax;
                  best_ay_ff   <= tok_w[MAX_POINTS].ay;
                  best_bx_ff   <= tok_w[MAX_POINTS].bx;
                  best_by_ff   <= tok_w[MAX_POINTS].by;
                  count_ff     <= count_ff + CNT_W'(1);
                  state_ff     <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!last_ff) begin
                  state_ff <= ST_IDLE;
               end else if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_dist_ff  <= found ? best_dist_ff[DIST_W-1:0] : '0;
                  rsp_ax_ff    <= found ? best_ax_ff : '0;
                  rsp_ay_ff    <= found ? best_ay_ff : '0;
                  rsp_bx_ff    <= found ? best_bx_ff : '0;
                  rsp_by_ff    <= found ? best_by_ff : '0;
                  rsp_found_ff <= found;
                  rsp_ovf_ff   <= overflow_ff;
                  // Clear the set for the next one.
                  count_ff     <= '0;
                  best_dist_ff <= DIST_NONE;
                  best_idx_ff  <= '0;
                  best_ax_ff   <= '0;
                  best_ay_ff   <= '0;
                  best_bx_ff   <= '0;
                  best_by_ff   <= '0;
                  overflow_ff  <= 1'b0;
                  last_ff      <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_sq_dist = rsp_dist_ff;
   assign rsp_first_x     = rsp_ax_ff;
   assign rsp_first_y     = rsp_ay_ff;
   assign rsp_second_x    = rsp_bx_ff;
   assign rsp_second_y    = rsp_by_ff;
   assign rsp_pair_found  = rsp_found_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

endmodule
